// ===== rtl/eir_pkg.sv =====
// Package for the extended I/O interrupt router: codes, register map,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package eir_pkg;

  localparam int DEF_NUM_SOURCES    = 256;
  localparam int DEF_NUM_CORES      = 4;
  localparam int DEF_LINES_PER_CORE = 4;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_IRQ   = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Byte offsets inside the register window (lane addresses are 18 bits).
  localparam logic [17:0] R_NODE      = 18'h000a0;
  localparam logic [17:0] R_IPMAP     = 18'h000c0;
  localparam logic [17:0] R_IPMAP_END = 18'h000c8;
  localparam logic [17:0] R_EN        = 18'h00200;
  localparam logic [17:0] R_BOUNCE    = 18'h00280;
  localparam logic [17:0] R_STATUS    = 18'h00300;
  localparam logic [17:0] R_CMAP      = 18'h00800;
  localparam logic [17:0] R_CSTAT     = 18'h10000;
  localparam logic [17:0] R_CSTAT_END = 18'h20000;
  localparam logic [17:0] BANK_SPAN   = 18'h00020;
  localparam logic [17:0] CMAP_SPAN   = 18'h00100;

  typedef enum logic [2:0] {
    REG_NONE,
    REG_EN,
    REG_BOUNCE,
    REG_STATUS,
    REG_CSTAT,
    REG_IPMAP,
    REG_CMAP,
    REG_NODE
  } eir_region_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE_REQ,
    ST_LANE_DATA,
    ST_BIT_SCAN,
    ST_ROUTE,
    ST_MAP,
    ST_RMW,
    ST_DONE
  } eir_state_t;

  typedef struct packed {
    logic load;
    logic lane_req;
    logic lane_exec;
    logic lane_next;
    logic pick;
    logic route;
    logic map;
    logic rmw;
  } eir_cmd_t;

  typedef struct packed {
    logic go_lanes;
    logic go_src;
    logic last_lane;
    logic exec_mask_any;
    logic mask_any;
    logic gate_ok;
    logic core_ok;
    logic is_src;
  } eir_stat_t;

  function automatic eir_region_t eir_decode(input logic [17:0] a);
    eir_region_t r;
    r = REG_NONE;
    if (a >= R_EN && a < R_EN + BANK_SPAN) r = REG_EN;
    else if (a >= R_BOUNCE && a < R_BOUNCE + BANK_SPAN) r = REG_BOUNCE;
    else if (a >= R_STATUS && a < R_STATUS + BANK_SPAN) r = REG_STATUS;
    else if (a >= R_CSTAT && a < R_CSTAT_END) r = REG_CSTAT;
    else if (a >= R_IPMAP && a < R_IPMAP_END) r = REG_IPMAP;
    else if (a >= R_CMAP && a < R_CMAP + CMAP_SPAN) r = REG_CMAP;
    else if (a >= R_NODE && a < R_IPMAP) r = REG_NODE;
    return r;
  endfunction

endpackage

// ===== rtl/eir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/eir_ctrl.sv =====
// Controller state machine of the interrupt router: sequences byte lanes,
// source re-evaluation and the result strobe. Depends on eir_pkg.
module eir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  eir_pkg::eir_stat_t stat,
  output eir_pkg::eir_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import eir_pkg::*;

  eir_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != ST_IDLE);
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.go_lanes) state_next = ST_LANE_REQ;
          else if (stat.go_src) state_next = ST_ROUTE;
          else state_next = ST_DONE;
        end
      end
      ST_LANE_REQ: begin
        cmd.lane_req = 1'b1;
        state_next   = ST_LANE_DATA;
      end
      ST_LANE_DATA: begin
        cmd.lane_exec = 1'b1;
        if (stat.exec_mask_any) state_next = ST_BIT_SCAN;
        else if (stat.last_lane) state_next = ST_DONE;
        else begin
          cmd.lane_next = 1'b1;
          state_next    = ST_LANE_REQ;
        end
      end
      ST_BIT_SCAN: begin
        if (stat.mask_any) begin
          cmd.pick   = 1'b1;
          state_next = ST_ROUTE;
        end else if (stat.last_lane) state_next = ST_DONE;
        else begin
          cmd.lane_next = 1'b1;
          state_next    = ST_LANE_REQ;
        end
      end
      ST_ROUTE: begin
        cmd.route = 1'b1;
        if (stat.gate_ok) state_next = ST_MAP;
        else state_next = stat.is_src ? ST_DONE : ST_BIT_SCAN;
      end
      ST_MAP: begin
        cmd.map = 1'b1;
        if (stat.core_ok) state_next = ST_RMW;
        else state_next = stat.is_src ? ST_DONE : ST_BIT_SCAN;
      end
      ST_RMW: begin
        cmd.rmw    = 1'b1;
        state_next = stat.is_src ? ST_DONE : ST_BIT_SCAN;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
endmodule

// ===== rtl/eir_dp.sv =====
// Datapath of the interrupt router: register file, byte-lane decode, core map,
// per-core status and line pending memories, line level register.
// Depends on eir_pkg and eir_ram.
module eir_dp #(
  parameter int NUM_SOURCES    = eir_pkg::DEF_NUM_SOURCES,
  parameter int NUM_CORES      = eir_pkg::DEF_NUM_CORES,
  parameter int LINES_PER_CORE = eir_pkg::DEF_LINES_PER_CORE
) (
  input  logic               clk,
  input  logic               rst,
  input  eir_pkg::eir_cmd_t  cmd,
  output eir_pkg::eir_stat_t stat,
  input  logic [1:0]         kind,
  input  logic [16:0]        offset,
  input  logic [1:0]         access_size,
  input  logic [31:0]        write_data,
  input  logic [7:0]         irq_number,
  input  logic               irq_level,
  output logic [31:0]        read_data,
  output logic [15:0]        line_levels
);
  import eir_pkg::*;

  localparam int NWORDS   = NUM_SOURCES / 32;
  localparam int NBYTES   = NUM_SOURCES / 8;
  localparam int NLINES   = NUM_CORES * LINES_PER_CORE;
  localparam int SRC_W    = $clog2(NUM_SOURCES);
  localparam int BYTE_W   = $clog2(NBYTES);
  localparam int WORD_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CORE_W   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int LINE_W   = $clog2(NLINES);
  localparam int CS_DEPTH = NUM_CORES * NWORDS;
  localparam int LP_DEPTH = NLINES * NWORDS;
  localparam int CS_AW    = (CS_DEPTH > 1) ? $clog2(CS_DEPTH) : 1;
  localparam int LP_AW    = (LP_DEPTH > 1) ? $clog2(LP_DEPTH) : 1;

  // latched transaction
  logic [1:0]  kind_q, size_q;
  logic [16:0] off_q;
  logic [31:0] data_q;
  logic [1:0]  lane_k;
  logic [17:0] lane_addr;
  logic [31:0] rd;
  logic [7:0]  mask, lvl;
  logic [4:0]  base_b;
  logic [7:0]  cur_src;
  logic        cur_level;
  logic [CORE_W-1:0] core_q;
  logic [LINE_W-1:0] line_q;
  logic [CS_AW-1:0]  cs_raddr_q;
  logic [LP_AW-1:0]  lp_raddr_q;

  // architectural state
  logic [NUM_SOURCES-1:0] en_bits, bn_bits, st_bits, cm_valid;
  logic [CS_DEPTH-1:0]    cs_nz;
  logic [LP_DEPTH-1:0]    lp_nz;
  logic [3:0]  ipmap [8];
  logic [1:0]  grp_route [8];
  logic [7:0]  node_b [32];
  logic [15:0] line_lvl;

  // memories
  logic             cm_we, cs_we, lp_we;
  logic [SRC_W-1:0] cm_waddr, cm_raddr;
  logic [7:0]       cm_wdata, cm_rdata;
  logic [CS_AW-1:0] cs_waddr, cs_raddr;
  logic [31:0]      cs_wdata, cs_rdata;
  logic [LP_AW-1:0] lp_raddr;
  logic [31:0]      lp_wdata, lp_rdata;

  eir_ram #(.WIDTH(8), .DEPTH(NUM_SOURCES)) u_cmap (
    .clk, .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata), .raddr(cm_raddr),
    .rdata(cm_rdata));
  eir_ram #(.WIDTH(32), .DEPTH(CS_DEPTH)) u_cstat (
    .clk, .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata), .raddr(cs_raddr),
    .rdata(cs_rdata));
  eir_ram #(.WIDTH(32), .DEPTH(LP_DEPTH)) u_lpend (
    .clk, .we(lp_we), .waddr(lp_raddr_q), .wdata(lp_wdata), .raddr(lp_raddr),
    .rdata(lp_rdata));

  // lane decode
  logic [17:0] lane_a;
  eir_region_t region;
  logic [4:0]  lb;
  logic [BYTE_W-1:0] bi;
  logic        byte_ok, lane_core_ok, cmap_ok;
  logic [7:0]  d, old_en, old_st, old_cs, rbyte, ex_mask, ex_lvl;
  logic [31:0] cs_m, cs_lane_new, cs_upd_new, lp_m, lp_new, bitm;
  logic [7:0]  cm_lane, cm_upd;
  logic [2:0]  pick_idx;
  logic [1:0]  ip_low;
  logic [SRC_W-1:0]  src_i;
  logic [WORD_W-1:0] w_i;
  logic [CORE_W-1:0] upd_core;
  logic [LINE_W-1:0] upd_line;
  logic [NWORDS-1:0] row;
  logic [LINE_W+3:0] line_ext;
  logic [7:0]  lane_core;

  assign lane_a    = {1'b0, off_q} + 18'(lane_k);
  assign region    = eir_decode(lane_addr);
  assign lb        = lane_addr[4:0];
  assign bi        = lb[BYTE_W-1:0];
  assign byte_ok   = {1'b0, lb} < 6'(NBYTES);
  assign lane_core = lane_addr[15:8];
  assign lane_core_ok = lane_core < 8'(NUM_CORES);
  assign cmap_ok   = {1'b0, lane_addr[7:0]} < 9'(NUM_SOURCES);
  assign d         = data_q[8*lane_k +: 8];
  assign old_en    = en_bits[8*bi +: 8];
  assign old_st    = st_bits[8*bi +: 8];
  assign cs_m      = cs_nz[cs_raddr_q] ? cs_rdata : 32'd0;
  assign lp_m      = lp_nz[lp_raddr_q] ? lp_rdata : 32'd0;
  assign old_cs    = cs_m[8*lb[1:0] +: 8];
  assign cm_lane   = cm_valid[lane_addr[SRC_W-1:0]] ? cm_rdata : 8'd0;

  assign src_i    = cur_src[SRC_W-1:0];
  assign w_i      = cur_src[5 +: WORD_W];
  assign bitm     = 32'd1 << cur_src[4:0];
  assign cm_upd   = cm_valid[src_i] ? cm_rdata : 8'd0;
  assign upd_core = cm_upd[CORE_W-1:0];
  assign upd_line = LINE_W'(upd_core) * LINE_W'(LINES_PER_CORE)
                  + LINE_W'(grp_route[cur_src[7:5]]);
  assign line_ext = (LINE_W + 4)'(line_q);

  always_comb begin
    cs_lane_new = cs_m;
    cs_lane_new[8*lb[1:0] +: 8] = old_cs & ~d;
    cs_upd_new  = cur_level ? (cs_m | bitm) : (cs_m & ~bitm);
    lp_new      = cur_level ? (lp_m | bitm) : (lp_m & ~bitm);
    row         = lp_nz[line_q*NWORDS +: NWORDS];
    row[w_i]    = (lp_new != 32'd0);
  end

  // read byte and the set of sources a write touches
  always_comb begin
    rbyte   = 8'd0;
    ex_mask = 8'd0;
    ex_lvl  = 8'd0;
    unique case (region)
      REG_EN:     rbyte = byte_ok ? old_en : 8'd0;
      REG_BOUNCE: rbyte = byte_ok ? bn_bits[8*bi +: 8] : 8'd0;
      REG_STATUS: rbyte = byte_ok ? old_st : 8'd0;
      REG_CSTAT:  rbyte = (byte_ok && lane_core_ok) ? old_cs : 8'd0;
      REG_IPMAP:  rbyte = {4'd0, ipmap[lane_addr[2:0]]};
      REG_CMAP:   rbyte = cmap_ok ? cm_lane : 8'd0;
      REG_NODE:   rbyte = node_b[lb];
      default:    rbyte = 8'd0;
    endcase
    if (kind_q == KIND_WRITE && byte_ok) begin
      case (region)
        REG_EN: begin
          ex_mask = old_en ^ d;
          ex_lvl  = d;
        end
        REG_STATUS: ex_mask = old_st & d;
        REG_CSTAT:  ex_mask = lane_core_ok ? (old_cs & d) : 8'd0;
        default:    ex_mask = 8'd0;
      endcase
    end
  end

  always_comb begin
    pick_idx = 3'd0;
    for (int i = 7; i >= 0; i--) if (mask[i]) pick_idx = 3'(i);
    ip_low = 2'd0;
    for (int i = 3; i >= 0; i--) if (d[i]) ip_low = 2'(i);
  end

  // memory ports
  always_comb begin
    cm_raddr = cmd.lane_req ? lane_a[SRC_W-1:0] : src_i;
    cm_we    = cmd.lane_exec && kind_q == KIND_WRITE && region == REG_CMAP && cmap_ok;
    cm_waddr = lane_addr[SRC_W-1:0];
    cm_wdata = d;
    if (cmd.lane_req)
      cs_raddr = CS_AW'(lane_a[15:8]) * CS_AW'(NWORDS) + CS_AW'(lane_a[4:2]);
    else
      cs_raddr = CS_AW'(upd_core) * CS_AW'(NWORDS) + CS_AW'(w_i);
    lp_raddr = LP_AW'(upd_line) * LP_AW'(NWORDS) + LP_AW'(w_i);
    cs_waddr = cs_raddr_q;
    cs_we    = cmd.rmw || (cmd.lane_exec && kind_q == KIND_WRITE && region == REG_CSTAT
                           && byte_ok && lane_core_ok);
    cs_wdata = cmd.rmw ? cs_upd_new : cs_lane_new;
    lp_we    = cmd.rmw;
    lp_wdata = lp_new;
  end

  // transaction registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      off_q  <= offset;
      size_q <= access_size;
      data_q <= write_data;
      rd     <= 32'd0;
      lane_k <= 2'd0;
      cur_src   <= irq_number;
      cur_level <= irq_level;
    end
    if (cmd.lane_req) lane_addr <= lane_a;
    if (cmd.lane_next) lane_k <= lane_k + 2'd1;
    if (cmd.lane_req || cmd.map) cs_raddr_q <= cs_raddr;
    if (cmd.map) begin
      lp_raddr_q <= lp_raddr;
      core_q     <= upd_core;
      line_q     <= upd_line;
    end
    if (cmd.lane_exec) begin
      if (kind_q == KIND_READ) rd[8*lane_k +: 8] <= rbyte;
      lvl    <= ex_lvl;
      base_b <= lb;
    end
    if (cmd.pick) begin
      cur_src   <= {base_b, pick_idx};
      cur_level <= lvl[pick_idx];
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      en_bits  <= '0;
      bn_bits  <= '0;
      st_bits  <= '0;
      cm_valid <= '0;
      cs_nz    <= '0;
      lp_nz    <= '0;
      line_lvl <= '0;
      mask     <= '0;
      for (int i = 0; i < 8; i++) begin
        ipmap[i]     <= '0;
        grp_route[i] <= '0;
      end
      for (int i = 0; i < 32; i++) node_b[i] <= '0;
    end else begin
      if (cmd.load && kind == KIND_IRQ && {1'b0, irq_number} < 9'(NUM_SOURCES))
        st_bits[irq_number[SRC_W-1:0]] <= irq_level;
      if (cmd.lane_exec) begin
        mask <= ex_mask;
        if (kind_q == KIND_WRITE) begin
          case (region)
            REG_EN:     if (byte_ok) en_bits[8*bi +: 8] <= d;
            REG_BOUNCE: if (byte_ok) bn_bits[8*bi +: 8] <= d;
            REG_STATUS: if (byte_ok) st_bits[8*bi +: 8] <= old_st & ~d;
            REG_CSTAT:
              if (byte_ok && lane_core_ok) cs_nz[cs_raddr_q] <= (cs_lane_new != 32'd0);
            REG_IPMAP: begin
              ipmap[lane_addr[2:0]] <= d[3:0];
              if (d[3:0] != 4'd0) grp_route[lane_addr[2:0]] <= ip_low;
            end
            REG_CMAP:   if (cmap_ok) cm_valid[lane_addr[SRC_W-1:0]] <= 1'b1;
            REG_NODE:   node_b[lb] <= d;
            default: ;
          endcase
        end
      end
      if (cmd.pick) mask[pick_idx] <= 1'b0;
      // drop the status bit of a source that falls
      if (cmd.route && !cur_level) st_bits[src_i] <= 1'b0;
      if (cmd.rmw) begin
        cs_nz[cs_raddr_q] <= (cs_upd_new != 32'd0);
        lp_nz[lp_raddr_q] <= (lp_new != 32'd0);
        if (line_ext < (LINE_W + 4)'(16)) line_lvl[line_ext[3:0]] <= |row;
      end
    end
  end

  always_comb begin
    stat.go_lanes  = (kind == KIND_READ || kind == KIND_WRITE) && access_size != 2'd3;
    stat.go_src    = kind == KIND_IRQ && {1'b0, irq_number} < 9'(NUM_SOURCES);
    unique case (size_q)
      SIZE_BYTE: stat.last_lane = (lane_k == 2'd0);
      SIZE_HALF: stat.last_lane = (lane_k == 2'd1);
      SIZE_WORD: stat.last_lane = (lane_k == 2'd3);
      default:   stat.last_lane = 1'b1;
    endcase
    stat.exec_mask_any = |ex_mask;
    stat.mask_any      = |mask;
    stat.gate_ok       = !cur_level || (en_bits[src_i] && st_bits[src_i]);
    stat.core_ok       = cm_upd < 8'(NUM_CORES);
    stat.is_src        = (kind_q == KIND_IRQ);
  end

  assign read_data   = rd;
  assign line_levels = line_lvl;

  a_core_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rmw |-> (32'(core_q) < NUM_CORES))
    else $error("pending update for a core outside the core count");
  a_pick_has_bit: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |=> !mask[$past(pick_idx)])
    else $error("picked source left in the scan mask");
endmodule

// ===== rtl/extended_io_interrupt_router.sv =====
// Top level of the extended I/O interrupt router.
// Depends on eir_pkg, eir_ctrl, eir_dp (which holds the eir_ram instances).
//
// A transaction is taken when start is high and busy is low; its one result
// (read_data, line_levels) is shown for exactly one cycle with done high, and
// the receiver cannot stall it. Transactions are handled one at a time by a
// controller that walks the byte lanes of an access (for each lane, a registered
// memory read and then a decode and update step), then re-evaluates each source
// that a write touches by a scan, a core map read, a per-core status and pending
// read and a write back, plus a further scan per lane to find its mask empty.
// Read data for writes and level changes is zero. All architectural state is
// zero after reset with no clearing pass: memories are qualified by valid or
// non-zero flags kept in flip-flops.
module extended_io_interrupt_router #(
  parameter int NUM_SOURCES    = eir_pkg::DEF_NUM_SOURCES,
  parameter int NUM_CORES      = eir_pkg::DEF_NUM_CORES,
  parameter int LINES_PER_CORE = eir_pkg::DEF_LINES_PER_CORE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [16:0] offset,
  input  logic [1:0]  access_size,
  input  logic [31:0] write_data,
  input  logic [7:0]  irq_number,
  input  logic        irq_level,
  output logic        done,
  output logic [31:0] read_data,
  output logic [15:0] line_levels
);
  import eir_pkg::*;

  eir_cmd_t  cmd;
  eir_stat_t stat;

  // sequence the transaction
  eir_ctrl u_ctrl (
    .clk, .rst, .start, .stat, .cmd, .busy, .done
  );

  // hold the registers, memories and line levels
  eir_dp #(
    .NUM_SOURCES(NUM_SOURCES),
    .NUM_CORES(NUM_CORES),
    .LINES_PER_CORE(LINES_PER_CORE)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .kind, .offset, .access_size, .write_data, .irq_number, .irq_level,
    .read_data, .line_levels
  );

  // line levels move only inside a transaction
  a_lines_stable_idle: assert property (@(posedge clk) disable iff (rst)
    ($past(!busy) && $past(!start) && !$past(rst)) |-> $stable(line_levels))
    else $error("line levels changed while idle");
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for extended_io_interrupt_router: a directed table, then
// about a thousand random register and source-line transactions checked by a predictor.
// Depends on eir_pkg and the router RTL.
module testbench;
  import eir_pkg::*;

  localparam int NSRC   = DEF_NUM_SOURCES;
  localparam int NCORE  = DEF_NUM_CORES;
  localparam int NLPC   = DEF_LINES_PER_CORE;
  localparam int NLINE  = NCORE * NLPC;
  localparam int NWRD   = NSRC / 32;
  localparam int NRAND  = 1000;
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam logic [1:0] SIZE_BAD = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_READ;
  logic [16:0] offset = '0;
  logic [1:0]  access_size = SIZE_BYTE;
  logic [31:0] write_data = '0;
  logic [7:0]  irq_number = '0;
  logic        irq_level = 1'b0;
  logic        done;
  logic [31:0] read_data;
  logic [15:0] line_levels;

  extended_io_interrupt_router DUT (.*);

  always #4 clk = ~clk;

  typedef struct packed {
    logic [1:0]  k;
    logic [16:0] off;
    logic [1:0]  sz;
    logic [31:0] wd;
    logic [7:0]  src;
    logic        lvl;
  } access_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [15:0] lines;
  } outcome_t;

  typedef struct packed {
    access_t     acc;
    logic        typed;   // expected outcome written in the row
    outcome_t    want;
  } row_t;

  // Router state as the predictor sees it.
  logic [31:0] en_bits[NWRD];
  logic [31:0] bounce_bits[NWRD];
  logic [31:0] stat_bits[NWRD];
  logic [31:0] core_stat[NCORE][NWRD];
  logic [31:0] pend_set[NLINE][NWRD];
  logic [7:0]  ipmap_raw[8];
  logic [1:0]  group_line[8];
  logic [7:0]  src_core[NSRC];
  logic [15:0] node_type[16];
  logic [15:0] lines_up;

  outcome_t pending_outcomes[$];
  int errors = 0;
  int checked = 0;
  int n_rd = 0, n_wr = 0, n_irq = 0;

  // Recompute one line from its pending set.
  function automatic void refresh_line(int l);
    logic any;
    any = 1'b0;
    for (int i = 0; i < NWRD; i++) any |= |pend_set[l][i];
    if (l < 16) lines_up[l] = any;
  endfunction

  // Re-evaluate a source at a new level, with the routes as they stand now.
  function automatic void eval_source(int s, logic lvl);
    int w, b, ln, c, l;
    w = s >> 5; b = s & 31; ln = group_line[w & 7]; c = src_core[s];
    if (lvl) begin
      if (!en_bits[w][b] || !stat_bits[w][b]) return;
      if (c >= NCORE) return;
      l = c * NLPC + ln;
      core_stat[c][w][b] = 1'b1;
      pend_set[l][w][b] = 1'b1;
    end else begin
      stat_bits[w][b] = 1'b0;
      if (c >= NCORE) return;
      l = c * NLPC + ln;
      core_stat[c][w][b] = 1'b0;
      pend_set[l][w][b] = 1'b0;
    end
    refresh_line(l);
  endfunction

  function automatic logic [7:0] byte_rd(input logic [17:0] a);
    logic [17:0] b;
    int c;
    if (a >= R_EN && a < R_EN + BANK_SPAN) begin
      b = a - R_EN; return en_bits[b[4:2]][b[1:0]*8 +: 8];
    end
    if (a >= R_BOUNCE && a < R_BOUNCE + BANK_SPAN) begin
      b = a - R_BOUNCE; return bounce_bits[b[4:2]][b[1:0]*8 +: 8];
    end
    if (a >= R_STATUS && a < R_STATUS + BANK_SPAN) begin
      b = a - R_STATUS; return stat_bits[b[4:2]][b[1:0]*8 +: 8];
    end
    if (a >= R_CSTAT && a < R_CSTAT_END) begin
      b = a - R_CSTAT; c = b[15:8];
      return (c < NCORE) ? core_stat[c][a[4:2]][a[1:0]*8 +: 8] : 8'h00;
    end
    if (a >= R_IPMAP && a < R_IPMAP_END) return ipmap_raw[a - R_IPMAP];
    if (a >= R_CMAP && a < R_CMAP + CMAP_SPAN) return src_core[a - R_CMAP];
    if (a >= R_NODE && a < R_IPMAP) begin
      b = a - R_NODE; return node_type[b[4:1]][b[0]*8 +: 8];
    end
    return 8'h00;
  endfunction

  function automatic void byte_wr(input logic [17:0] a, input logic [7:0] d);
    logic [17:0] b;
    logic [7:0] prev;
    int c;
    if (a >= R_EN && a < R_EN + BANK_SPAN) begin
      b = a - R_EN;
      prev = en_bits[b[4:2]][b[1:0]*8 +: 8];
      en_bits[b[4:2]][b[1:0]*8 +: 8] = d;
      for (int i = 0; i < 8; i++)
        if (prev[i] != d[i]) eval_source(b * 8 + i, d[i]);
    end else if (a >= R_BOUNCE && a < R_BOUNCE + BANK_SPAN) begin
      b = a - R_BOUNCE;
      bounce_bits[b[4:2]][b[1:0]*8 +: 8] = d;
    end else if (a >= R_STATUS && a < R_STATUS + BANK_SPAN) begin
      b = a - R_STATUS;
      prev = stat_bits[b[4:2]][b[1:0]*8 +: 8];
      stat_bits[b[4:2]][b[1:0]*8 +: 8] = prev & ~d;
      for (int i = 0; i < 8; i++)
        if (prev[i] && d[i]) eval_source(b * 8 + i, 1'b0);
    end else if (a >= R_CSTAT && a < R_CSTAT_END) begin
      b = a - R_CSTAT; c = b[15:8];
      if (c >= NCORE) return;
      prev = core_stat[c][a[4:2]][a[1:0]*8 +: 8];
      core_stat[c][a[4:2]][a[1:0]*8 +: 8] = prev & ~d;
      // drop by the per-core status pattern, through the normal fall path
      for (int i = 0; i < 8; i++)
        if (prev[i] && d[i]) eval_source(a[4:0] * 8 + i, 1'b0);
    end else if (a >= R_IPMAP && a < R_IPMAP_END) begin
      b = a - R_IPMAP;
      ipmap_raw[b] = {4'h0, d[3:0]};
      if (d[3:0] != 0)
        for (int i = 3; i >= 0; i--) if (d[i]) group_line[b] = 2'(i);
    end else if (a >= R_CMAP && a < R_CMAP + CMAP_SPAN) begin
      src_core[a - R_CMAP] = d;
    end else if (a >= R_NODE && a < R_IPMAP) begin
      b = a - R_NODE;
      node_type[b[4:1]][b[0]*8 +: 8] = d;
    end
  endfunction

  // Apply one transaction to the predicted state; return its outcome.
  function automatic outcome_t route_access(access_t t);
    outcome_t o;
    int n;
    o.rd = '0;
    n = (t.sz == SIZE_BYTE) ? 1 : (t.sz == SIZE_HALF) ? 2 : (t.sz == SIZE_WORD) ? 4 : 0;
    if (t.k == KIND_READ) begin
      for (int k = 0; k < n; k++) o.rd[k*8 +: 8] = byte_rd(18'({1'b0, t.off} + k));
    end else if (t.k == KIND_WRITE) begin
      for (int k = 0; k < n; k++) byte_wr(18'({1'b0, t.off} + k), t.wd[k*8 +: 8]);
    end else if (t.k == KIND_IRQ && t.src < NSRC) begin
      stat_bits[t.src >> 5][t.src & 31] = t.lvl;
      eval_source(t.src, t.lvl);
    end
    o.lines = lines_up;
    return o;
  endfunction

  function automatic access_t mk(int k, int off, int sz, logic [31:0] wd, int src,
                                 int lvl);
    access_t t;
    t.k = 2'(k); t.off = 17'(off); t.sz = 2'(sz); t.wd = wd; t.src = 8'(src);
    t.lvl = lvl[0];
    return t;
  endfunction

  // Random transaction: mostly meaningful accesses and source changes, some noise.
  function automatic access_t rand_access();
    access_t t;
    int pick;
    logic [16:0] bases[6];
    bases = '{R_EN[16:0], R_STATUS[16:0], R_IPMAP[16:0], R_CMAP[16:0], R_BOUNCE[16:0],
              R_NODE[16:0]};
    t = mk($urandom_range(0, 2), $urandom, $urandom_range(0, 2), $urandom, $urandom,
           $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // source changes, mostly the low groups that get enabled most often
      t.k = KIND_IRQ;
      if ($urandom_range(0, 3) != 0) t.src = 8'($urandom_range(0, 63));
    end else if (pick < 85) begin
      t.k = ($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ;
      case ($urandom_range(0, 7))
        0, 1: t.off = 17'(bases[0] + $urandom_range(0, 33));
        2:    t.off = 17'(bases[1] + $urandom_range(0, 33));
        3:    t.off = 17'(bases[2] + $urandom_range(0, 9));
        4:    begin
          t.off = 17'(bases[3] + $urandom_range(0, 257));
          if ($urandom_range(0, 3) != 0) t.wd = $urandom & 32'h0303_0303;
        end
        5:    t.off = 17'(R_CSTAT[16:0] + ($urandom_range(0, 5) << 8)
                          + $urandom_range(0, 'h23));
        6:    t.off = 17'(bases[4] + $urandom_range(0, 33));
        default: t.off = 17'(bases[5] + $urandom_range(0, 33));
      endcase
      // enable writes lean toward setting bits so sources can be routed
      if (t.k == KIND_WRITE && t.off >= R_EN[16:0] && t.off < R_EN[16:0] + 34 &&
          $urandom_range(0, 1) != 0)
        t.wd = $urandom | $urandom;
    end else if (pick < 93) begin
      t.k = 2'($urandom_range(0, 3));
      t.sz = 2'($urandom_range(0, 3));
    end
    return t;
  endfunction

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no transaction outstanding: read_data %h line_levels %h",
               read_data, line_levels);
        errors++;
      end else begin
        e = pending_outcomes.pop_front();
        checked++;
        if (read_data !== e.rd) begin
          $error("read_data expected %h actual %h", e.rd, read_data);
          errors++;
        end
        if (line_levels !== e.lines) begin
          $error("line_levels expected %h actual %h", e.lines, line_levels);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("extended_io_interrupt_router test failed");
    $finish;
  end

  row_t rows[$];
  access_t plan[$];

  initial begin
    access_t t;
    outcome_t o;
    int burst, gap;

    for (int i = 0; i < NWRD; i++) begin
      en_bits[i] = '0; bounce_bits[i] = '0; stat_bits[i] = '0;
      for (int c = 0; c < NCORE; c++) core_stat[c][i] = '0;
      for (int l = 0; l < NLINE; l++) pend_set[l][i] = '0;
    end
    for (int i = 0; i < 8; i++) begin ipmap_raw[i] = '0; group_line[i] = '0; end
    for (int i = 0; i < NSRC; i++) src_core[i] = '0;
    for (int i = 0; i < 16; i++) node_type[i] = '0;
    lines_up = '0;

    // Directed table: typed outcomes only where obvious (right after reset, bad codes).
    rows.push_back('{mk(KIND_READ, R_EN, SIZE_WORD, 0, 0, 0), 1'b1, '{32'h0, 16'h0}});
    rows.push_back('{mk(KIND_READ, 17'h1ffff, SIZE_WORD, 0, 0, 0), 1'b1, '{32'h0, 16'h0}});
    rows.push_back('{mk(KIND_BAD, R_EN, SIZE_WORD, '1, 8'hff, 1), 1'b1, '{32'h0, 16'h0}});
    rows.push_back('{mk(KIND_WRITE, R_EN, SIZE_BAD, '1, 0, 0), 1'b1, '{32'h0, 16'h0}});
    rows.push_back('{mk(KIND_WRITE, R_EN, SIZE_WORD, '1, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_IRQ, 0, SIZE_BYTE, 0, 8'd0, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_READ, R_STATUS, SIZE_BYTE, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_READ, R_CSTAT, SIZE_WORD, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_IPMAP, SIZE_BYTE, 32'h0c, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_IRQ, 0, SIZE_BYTE, 0, 8'd1, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_STATUS, SIZE_BYTE, 32'h01, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_CMAP + 2, SIZE_HALF, 32'hff03, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_IRQ, 0, SIZE_BYTE, 0, 8'd2, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_IRQ, 0, SIZE_BYTE, 0, 8'd3, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_CSTAT + 17'h300, SIZE_BYTE, 32'h04, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_EN, SIZE_BYTE, 32'h00, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_IRQ, 0, SIZE_BYTE, 0, 8'd255, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_IRQ, 0, SIZE_BYTE, 0, 8'd255, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_NODE, SIZE_WORD, 32'hdeadbeef, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_READ, R_NODE + 30, SIZE_WORD, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, R_BOUNCE + 28, SIZE_WORD, '1, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_READ, R_EN + 30, SIZE_WORD, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_READ, R_CSTAT + 17'h4000, SIZE_WORD, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_WRITE, 17'h1ffff, SIZE_WORD, '1, 0, 0), 1'b0, '0});

    foreach (rows[i]) plan.push_back(rows[i].acc);
    for (int i = 0; i < NRAND; i++) plan.push_back(rand_access());

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst = $urandom_range(1, 20);
    t = plan[0];
    {kind, offset, access_size, write_data, irq_number, irq_level} <= t;
    start <= 1'b1;
    for (int i = 0; i < plan.size(); i++) begin
      // hold the transaction until the router takes it
      do @(posedge clk); while (busy);
      o = route_access(plan[i]);
      if (i < rows.size() && rows[i].typed) begin
        if (o !== rows[i].want) begin
          $error("predictor disagrees with table row %0d", i);
          errors++;
        end
        o = rows[i].want;
      end
      pending_outcomes.push_back(o);
      case (plan[i].k)
        KIND_READ:  n_rd++;
        KIND_WRITE: n_wr++;
        KIND_IRQ:   n_irq++;
        default:    ;
      endcase
      if (i + 1 == plan.size()) begin
        start <= 1'b0;
        break;
      end
      burst--;
      if (i == rows.size() + NRAND / 2 || burst == 0) begin
        start <= 1'b0;
        if (i == rows.size() + NRAND / 2) begin
          // drain: wait for every outstanding result
          while (pending_outcomes.size() != 0) @(posedge clk);
        end else begin
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        @(posedge clk);
        start <= 1'b1;
      end else begin
        start <= 1'b1;
      end
      {kind, offset, access_size, write_data, irq_number, irq_level} <= plan[i + 1];
    end

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d reads, %0d writes, %0d source changes; %0d results checked",
             n_rd, n_wr, n_irq, checked);
    if (errors == 0 && pending_outcomes.size() == 0)
      $display("extended_io_interrupt_router test passed");
    else
      $display("extended_io_interrupt_router test failed");
    $finish;
  end

endmodule
